// File: rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf-8 to code point decoder
// used by utf8d_step and utf8_to_codepoint_decoder; no dependencies
package utf8d_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned PendWidth = 2;
   localparam int unsigned QDepth    = 3;

   localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

   // class of one input byte, from its leading bits
   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD
   } byte_class_type;

   // one result item as it sits in the output queue
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               is_error;
      logic               last_of_run;
   } result_type;

   // what one byte step produces: up to two results and the next decoder state
   typedef struct packed {
      logic [1:0]           num;
      result_type           res0;
      result_type           res1;
      logic [CpWidth-1:0]   acc;
      logic [PendWidth-1:0] pend;
   } step_type;

endpackage

// File: rtl/utf8_to_codepoint_decoder.sv
// utf8_to_codepoint_decoder: streaming lenient utf-8 decoder, one byte per transfer
// depends on utf8d_pkg and utf8d_step
// results enter the result queue as their byte is taken on req_; rsp_ offers the queue head
// throughput: one byte per cycle while at most one result waits; a byte that yields two
// results stalls req_ until at most one result waits again, which needs rsp_ to take results
// reset: synchronous, clears the pending count, the accumulator and the result queue
module utf8_to_codepoint_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tuser,   // is_error
   output logic        rsp_tlast    // last_of_run
);
   import utf8d_pkg::*;

   logic [CpWidth-1:0]   acc_ff,  acc_in;
   logic [PendWidth-1:0] pend_ff, pend_in;
   logic [1:0]           cnt_ff,  cnt_in;
   result_type           q_ff [QDepth];
   result_type           q_in [QDepth];
   step_type             step;
   logic                 push;
   logic                 pop;
   logic [1:0]           base;
   logic [1:0]           num;

   // byte decode against the current state
   utf8d_step u_step (
      .byte_in       (req_tdata),
      .end_of_string (req_tlast),
      .acc           (acc_ff),
      .pend          (pend_ff),
      .step          (step)
   );

   // handshake
   assign req_tready = (cnt_ff <= 2'd1);
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign num        = push ? step.num : 2'd0;
   assign base       = cnt_ff - {1'b0, pop};

   // decoder state update
   assign acc_in  = push ? step.acc  : acc_ff;
   assign pend_in = push ? step.pend : pend_ff;

   // result queue: shift on pop, append new results behind the survivors
   always_comb begin
      for (int i = 0; i < QDepth; i++) begin
         if (pop && (i < QDepth - 1)) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if ((num != 2'd0) && (base == 2'(i))) begin
            q_in[i] = step.res0;
         end
         if ((num == 2'd2) && ((base + 2'd1) == 2'(i))) begin
            q_in[i] = step.res1;
         end
      end
   end

   assign cnt_in = base + num;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDepth; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // output head
   assign rsp_tdata = {3'b000, q_ff[0].code_point};
   assign rsp_tuser = q_ff[0].is_error;
   assign rsp_tlast = q_ff[0].last_of_run;

   // end of string leaves a clean decoder state
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> (pend_ff == '0) && (acc_ff == '0))
      else $error("state not cleared after end of string");

   // an error result always carries the replacement code point
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[20:0] == Replacement))
      else $error("error result without replacement code point");

   // queue stays empty when nothing is taken in
   a_queue_idle: assert property (@(posedge clock) disable iff (reset)
      ((cnt_ff == 2'd0) && !push) |=> (cnt_ff == 2'd0))
      else $error("result appeared without an input transfer");

   // a byte that starts a sequence without end of string yields nothing
   a_lead_silent: assert property (@(posedge clock) disable iff (reset)
      (push && !req_tlast && (req_tdata[7:6] == 2'b11) && (req_tdata[7:3] != 5'b11111))
      |-> (step.num == 2'd0))
      else $error("lead byte produced a result");

   // a stalled head result holds its value
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(q_ff[0]))
      else $error("head result changed while stalled");

endmodule

// File: rtl/utf8d_step.sv
// utf8d_step: combinational decode of one utf-8 byte against the current state
// depends on utf8d_pkg
module utf8d_step (
   input  logic [7:0]                         byte_in,
   input  logic                               end_of_string,
   input  logic [utf8d_pkg::CpWidth-1:0]      acc,
   input  logic [utf8d_pkg::PendWidth-1:0]    pend,
   output utf8d_pkg::step_type                step
);
   import utf8d_pkg::*;

   byte_class_type     cls;
   logic               pre_vld;
   logic               main_vld;
   result_type         main_res;
   logic               eos_vld;
   logic [CpWidth-1:0] acc_mid;
   logic [PendWidth-1:0] pend_mid;
   result_type         pre_res;
   result_type         eos_res;

   // classify the byte by its top bits
   always_comb begin
      priority casez (byte_in)
         8'b0???????: cls = CLS_ASCII;
         8'b10??????: cls = CLS_CONT;
         8'b110?????: cls = CLS_LEAD2;
         8'b1110????: cls = CLS_LEAD3;
         8'b11110???: cls = CLS_LEAD4;
         default:     cls = CLS_BAD;
      endcase
   end

   // per-class results and state update
   always_comb begin
      pre_vld  = 1'b0;
      main_vld = 1'b0;
      main_res = '{code_point: Replacement, is_error: 1'b1, last_of_run: 1'b0};
      acc_mid  = acc;
      pend_mid = pend;
      unique case (cls)
         CLS_ASCII: begin
            pre_vld  = (pend != '0);
            pend_mid = '0;
            main_vld = 1'b1;
            main_res = '{code_point: {{(CpWidth-8){1'b0}}, byte_in},
                         is_error: 1'b0, last_of_run: 1'b0};
         end
         CLS_CONT: begin
            if (pend != '0) begin
               acc_mid  = {acc[CpWidth-7:0], byte_in[5:0]};
               pend_mid = pend - 1'b1;
               main_vld = (pend == PendWidth'(1));
               main_res = '{code_point: {acc[CpWidth-7:0], byte_in[5:0]},
                            is_error: 1'b0, last_of_run: 1'b0};
            end else begin
               // stray continuation byte
               main_vld = 1'b1;
            end
         end
         CLS_LEAD2: begin
            pend_mid = PendWidth'(1);
            acc_mid  = {{(CpWidth-5){1'b0}}, byte_in[4:0]};
         end
         CLS_LEAD3: begin
            pend_mid = PendWidth'(2);
            acc_mid  = {{(CpWidth-4){1'b0}}, byte_in[3:0]};
         end
         CLS_LEAD4: begin
            pend_mid = PendWidth'(3);
            acc_mid  = {{(CpWidth-3){1'b0}}, byte_in[2:0]};
         end
         CLS_BAD: begin
            main_vld = 1'b1;
            pend_mid = '0;
         end
         default: begin
            main_vld = 1'b1;
            pend_mid = '0;
         end
      endcase
   end

   // end of string flushes any unfinished sequence
   assign eos_vld = end_of_string && (pend_mid != '0);
   assign pre_res = '{code_point: Replacement, is_error: 1'b1, last_of_run: 1'b0};
   assign eos_res = '{code_point: Replacement, is_error: 1'b1, last_of_run: 1'b0};

   // pack present results in order, mark the last one
   always_comb begin
      step.res0 = pre_res;
      step.res1 = main_res;
      step.num  = 2'd0;
      if (pre_vld) begin
         // ascii after a pending sequence: the main result is always present
         step.res0 = pre_res;
         step.res1 = main_res;
         step.num  = 2'd2;
      end else if (main_vld) begin
         step.res0 = main_res;
         step.res1 = eos_res;
         step.num  = eos_vld ? 2'd2 : 2'd1;
      end else if (eos_vld) begin
         step.res0 = eos_res;
         step.num  = 2'd1;
      end
      step.res0.last_of_run = (step.num == 2'd1);
      step.res1.last_of_run = 1'b1;
      step.acc  = end_of_string ? '0 : acc_mid;
      step.pend = end_of_string ? '0 : pend_mid;
   end

endmodule
